### rtl/stlm_pkg.sv
package stlm_pkg;

    localparam int VALUE_W = 32;

    typedef logic [1:0] t_opcode;

    localparam t_opcode OP_APPEND_FIRST  = 2'd0;
    localparam t_opcode OP_APPEND_SECOND = 2'd1;
    localparam t_opcode OP_MERGE         = 2'd2;

    typedef logic signed [VALUE_W-1:0] t_value;

endpackage

### rtl/sorted_two_list_merge.sv
// two-way stable merge of two bounded sorted lists
//
// requests come in on i_start/i_opcode/i_item_value and are taken at a rising
// edge where i_start is high and o_busy is low. an append (first or second
// list) gives no result; an append to a full list is dropped and remembered
// until the next merge. opcode 3 is ignored. a merge request streams every
// stored value, one result per cycle, on o_merged_value with o_strobe high
// for exactly one cycle each. the edge that takes the request reads both
// heads from the rams and enters the emit state, and each result is
// registered from there; o_busy stays high while results stream and is low
// again with the last one. results come from one shared signed comparator
// looking at the registered heads of the two list rams, each ram fetching
// its next head in the cycle its value is picked. o_is_last marks the final
// result, o_dropped repeats the overflow flag on every result. a merge of
// two empty lists leaves o_busy low and gives one registered result with
// o_is_empty in the cycle after the request is taken.
// a merge clears both counts and the overflow flag.
// the receiver cannot stall: every strobed result must be taken.
// reset clears counts, overflow flag and sequencer; ram contents stay.
module sorted_two_list_merge #(
    parameter int LIST_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  stlm_pkg::t_opcode i_opcode,
    input  stlm_pkg::t_value  i_item_value,
    output logic              o_strobe,
    output stlm_pkg::t_value  o_merged_value,
    output logic              o_is_last,
    output logic              o_is_empty,
    output logic              o_dropped
);

    import stlm_pkg::*;

    localparam int CntW  = $clog2(LIST_DEPTH + 1);
    localparam int AddrW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [CntW-1:0]   r_cnt1, r_cnt2;
    logic [CntW-1:0]   r_i1, r_i2;
    logic              r_overflow;
    logic              r_strobe;
    t_value            r_value;
    logic              r_last;
    logic              r_empty;
    logic              r_dropped;

    logic              accept;
    logic              first_live, second_live, take_second, last;
    logic [CntW-1:0]   i1_inc, i2_inc;
    logic              we1, we2, re1, re2;
    logic [AddrW-1:0]  raddr1, raddr2;
    logic [VALUE_W-1:0] rd1, rd2;

    assign accept = i_start && (r_state == S_IDLE);

    assign i1_inc      = r_i1 + CntW'(1);
    assign i2_inc      = r_i2 + CntW'(1);
    assign first_live  = r_i1 < r_cnt1;
    assign second_live = r_i2 < r_cnt2;
    // first list wins ties, so only a strictly greater head yields to the second
    assign take_second = !first_live || (second_live && ($signed(rd1) > $signed(rd2)));
    assign last        = take_second ? ((i2_inc == r_cnt2) && !first_live)
                                     : ((i1_inc == r_cnt1) && !second_live);

    assign we1 = accept && (i_opcode == OP_APPEND_FIRST)  && (r_cnt1 < CntW'(LIST_DEPTH));
    assign we2 = accept && (i_opcode == OP_APPEND_SECOND) && (r_cnt2 < CntW'(LIST_DEPTH));

    // fetch both heads when a merge is taken, then prefetch the next head of whichever list is consumed this cycle
    always_comb begin
        re1    = 1'b0;
        re2    = 1'b0;
        raddr1 = '0;
        raddr2 = '0;
        if (accept && (i_opcode == OP_MERGE)) begin
            re1 = 1'b1;
            re2 = 1'b1;
        end else if (r_state == S_EMIT) begin
            if (take_second) begin
                re2    = i2_inc < r_cnt2;
                raddr2 = i2_inc[AddrW-1:0];
            end else begin
                re1    = i1_inc < r_cnt1;
                raddr1 = i1_inc[AddrW-1:0];
            end
        end
    end

    stlm_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(LIST_DEPTH)
    ) u_first_ram (
        .i_clk  (i_clk),
        .i_we   (we1),
        .i_waddr(r_cnt1[AddrW-1:0]),
        .i_wdata(i_item_value),
        .i_re   (re1),
        .i_raddr(raddr1),
        .o_rdata(rd1)
    );

    stlm_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(LIST_DEPTH)
    ) u_second_ram (
        .i_clk  (i_clk),
        .i_we   (we2),
        .i_waddr(r_cnt2[AddrW-1:0]),
        .i_wdata(i_item_value),
        .i_re   (re2),
        .i_raddr(raddr2),
        .o_rdata(rd2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt1     <= '0;
            r_cnt2     <= '0;
            r_i1       <= '0;
            r_i2       <= '0;
            r_overflow <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_opcode)
                            OP_APPEND_FIRST: begin
                                if (we1) begin
                                    r_cnt1 <= r_cnt1 + CntW'(1);
                                end else begin
                                    r_overflow <= 1'b1;
                                end
                            end
                            OP_APPEND_SECOND: begin
                                if (we2) begin
                                    r_cnt2 <= r_cnt2 + CntW'(1);
                                end else begin
                                    r_overflow <= 1'b1;
                                end
                            end
                            OP_MERGE: begin
                                if ((r_cnt1 == '0) && (r_cnt2 == '0)) begin
                                    r_strobe   <= 1'b1;
                                    r_value    <= '0;
                                    r_last     <= 1'b1;
                                    r_empty    <= 1'b1;
                                    r_dropped  <= r_overflow;
                                    r_overflow <= 1'b0;
                                end else begin
                                    r_i1    <= '0;
                                    r_i2    <= '0;
                                    r_state <= S_EMIT;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_EMIT: begin
                    r_strobe  <= 1'b1;
                    r_value   <= take_second ? t_value'(rd2) : t_value'(rd1);
                    r_last    <= last;
                    r_empty   <= 1'b0;
                    r_dropped <= r_overflow;
                    if (take_second) begin
                        r_i2 <= i2_inc;
                    end else begin
                        r_i1 <= i1_inc;
                    end
                    if (last) begin
                        r_state    <= S_IDLE;
                        r_cnt1     <= '0;
                        r_cnt2     <= '0;
                        r_overflow <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_merged_value = r_value;
    assign o_is_last      = r_last;
    assign o_is_empty     = r_empty;
    assign o_dropped      = r_dropped;

    a_emit_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (first_live || second_live))
        else $error("merge running with both lists exhausted");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt1 <= CntW'(LIST_DEPTH)) && (r_cnt2 <= CntW'(LIST_DEPTH)))
        else $error("list count beyond depth");

    a_last_frees_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_last) |-> !o_busy)
        else $error("block still busy after last result");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_empty) |-> o_is_last)
        else $error("empty result not marked last");

    a_merge_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && last) |=> (r_cnt1 == '0 && r_cnt2 == '0 && !r_overflow))
        else $error("merge end did not clear list state");

endmodule

### rtl/stlm_ram.sv
module stlm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AddrW-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### tb/sorted_two_list_merge_test.sv
module sorted_two_list_merge_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stlm_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int REQUEST_TARGET = 200;
    localparam t_opcode OP_UNUSED = 2'd3;

    typedef struct {
        t_opcode op;
        t_value  value;
        bit      drain_first;
    } merge_request_t;

    typedef struct {
        t_value value;
        logic   last;
        logic   empty;
        logic   dropped;
    } merge_word_t;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_start = 1'b0;
    t_opcode i_opcode = OP_MERGE;
    t_value  i_item_value = '0;
    logic    o_busy;
    logic    o_strobe;
    t_value  o_merged_value;
    logic    o_is_last;
    logic    o_is_empty;
    logic    o_dropped;

    merge_request_t request_backlog[$];
    merge_word_t    merge_words_due[$];

    // shadow copy of the two lists and the overflow flag
    t_value shadow_first[$];
    t_value shadow_second[$];
    bit     shadow_overflow = 1'b0;

    bit took_request = 1'b0;
    int gap_left = 0;
    int burst_left = 0;
    int fail_count = 0;
    int request_count = 0;

    sorted_two_list_merge #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .o_busy(o_busy),
        .i_opcode(i_opcode),
        .i_item_value(i_item_value),
        .o_strobe(o_strobe),
        .o_merged_value(o_merged_value),
        .o_is_last(o_is_last),
        .o_is_empty(o_is_empty),
        .o_dropped(o_dropped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void predict_merge_words(t_opcode op, t_value value);
        int ia;
        int ib;
        int total;
        bit take_second;
        merge_word_t w;
        ia = 0;
        ib = 0;
        case (op)
            OP_APPEND_FIRST: begin
                if (shadow_first.size() < LIST_DEPTH) shadow_first.push_back(value);
                else shadow_overflow = 1'b1;
            end
            OP_APPEND_SECOND: begin
                if (shadow_second.size() < LIST_DEPTH) shadow_second.push_back(value);
                else shadow_overflow = 1'b1;
            end
            OP_MERGE: begin
                total = shadow_first.size() + shadow_second.size();
                if (total == 0) begin
                    w = '{value: '0, last: 1'b1, empty: 1'b1, dropped: shadow_overflow};
                    merge_words_due.push_back(w);
                end
                for (int k = 0; k < total; k++) begin
                    if (ia >= shadow_first.size()) take_second = 1'b1;
                    else if (ib >= shadow_second.size()) take_second = 1'b0;
                    else take_second = shadow_first[ia] > shadow_second[ib];
                    w.value = take_second ? shadow_second[ib] : shadow_first[ia];
                    if (take_second) ib++;
                    else ia++;
                    w.last = (k + 1 == total);
                    w.empty = 1'b0;
                    w.dropped = shadow_overflow;
                    merge_words_due.push_back(w);
                end
                shadow_first.delete();
                shadow_second.delete();
                shadow_overflow = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst_left = $urandom_range(20, 40);
            return 0;
        end
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // driver: holds a request until it is taken, then idles or moves on
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !took_request) begin
            i_start <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_start <= 1'b0;
            i_item_value <= $urandom;
        end else if (request_backlog.size() == 0) begin
            i_start <= 1'b0;
        end else if (request_backlog[0].drain_first && merge_words_due.size() != 0) begin
            i_start <= 1'b0;
        end else begin
            i_opcode <= request_backlog[0].op;
            i_item_value <= request_backlog[0].value;
            i_start <= 1'b1;
            void'(request_backlog.pop_front());
            gap_left <= pick_gap();
        end
    end

    // monitor: checks strobed results, then predicts for a taken request
    always @(posedge i_clk) begin
        merge_word_t w;
        bit bad;
        took_request <= i_rst_n && i_start && !o_busy;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (merge_words_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: value %0d last %b empty %b dropped %b",
                                 o_merged_value, o_is_last, o_is_empty, o_dropped);
                end else begin
                    w = merge_words_due.pop_front();
                    bad = 1'b0;
                    if (o_merged_value !== w.value) bad = 1'b1;
                    if (o_is_last !== w.last) bad = 1'b1;
                    if (o_is_empty !== w.empty) bad = 1'b1;
                    if (o_dropped !== w.dropped) bad = 1'b1;
                    if (bad) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected value %0d last %b empty %b dropped %b, got value %0d last %b empty %b dropped %b",
                                     w.value, w.last, w.empty, w.dropped,
                                     o_merged_value, o_is_last, o_is_empty, o_dropped);
                    end
                end
            end
            if (i_start && !o_busy) predict_merge_words(i_opcode, i_item_value);
        end
    end

    task automatic add_request(t_opcode op, t_value value, bit drain_first = 1'b0);
        merge_request_t req;
        req = '{op: op, value: value, drain_first: drain_first};
        request_backlog.push_back(req);
        if (op != OP_UNUSED) request_count++;
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) return 0;
        if (r < 80) return $urandom_range(1, 6);
        if (r < 92) return $urandom_range(7, LIST_DEPTH);
        return $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 4);
    endfunction

    function automatic longint pick_start();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return -64'sd2147483648;
        if (r < 5) return longint'($signed($urandom_range(0, 40))) - 20;
        return longint'(t_value'($urandom));
    endfunction

    function automatic int unsigned pick_span();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 0;
        if (r < 5) return 3;
        if (r < 8) return 1000;
        return 32'h1000_0000;
    endfunction

    // next value of an ascending run, saturating at the top of the range, or a random value when scramble is set
    function automatic t_value next_in_run(inout longint cur, input int unsigned span,
                                           input bit scramble);
        if (scramble) return t_value'($urandom);
        cur = cur + longint'($urandom_range(0, span));
        if (cur > 64'sd2147483647) cur = 64'sd2147483647;
        return t_value'(cur);
    endfunction

    initial begin
        int n_first;
        int n_second;
        int c_first;
        int c_second;
        longint cur_first;
        longint cur_second;
        int unsigned span_first;
        int unsigned span_second;
        bit scramble;
        bit pick_first;
        bit first_group;

        // both lists empty
        add_request(OP_MERGE, '0);
        // extremes on the first list only
        add_request(OP_APPEND_FIRST, 32'sh8000_0000);
        add_request(OP_APPEND_FIRST, -32'sd1);
        add_request(OP_APPEND_FIRST, 32'sd0);
        add_request(OP_APPEND_FIRST, 32'sh7fff_ffff);
        add_request(OP_MERGE, 32'sh7fff_ffff);
        // second list only, with an ignored opcode in between
        add_request(OP_APPEND_SECOND, 32'sh8000_0000);
        add_request(OP_APPEND_SECOND, 32'sh7fff_ffff);
        add_request(OP_UNUSED, 32'sh5a5a_a5a5);
        add_request(OP_MERGE, '0);
        // equal heads on both lists
        add_request(OP_APPEND_FIRST, 32'sd5);
        add_request(OP_APPEND_FIRST, 32'sd5);
        add_request(OP_APPEND_SECOND, 32'sd3);
        add_request(OP_APPEND_SECOND, 32'sd5);
        add_request(OP_MERGE, '0);
        // out of order input
        add_request(OP_APPEND_FIRST, 32'sd10);
        add_request(OP_APPEND_FIRST, -32'sd10);
        add_request(OP_APPEND_SECOND, 32'sd0);
        add_request(OP_MERGE, '0);

        first_group = 1'b1;
        while (request_count < REQUEST_TARGET) begin
            n_first = pick_length();
            n_second = pick_length();
            c_first = 0;
            c_second = 0;
            cur_first = pick_start();
            cur_second = ($urandom_range(0, 2) == 0) ? cur_first : pick_start();
            span_first = pick_span();
            span_second = pick_span();
            scramble = ($urandom_range(0, 9) == 0);
            while (c_first < n_first || c_second < n_second) begin
                pick_first = (c_first < n_first) && (c_second >= n_second || $urandom_range(0, 1));
                if (pick_first) begin
                    add_request(OP_APPEND_FIRST, next_in_run(cur_first, span_first, scramble));
                    c_first++;
                end else begin
                    add_request(OP_APPEND_SECOND,
                                next_in_run(cur_second, span_second, scramble));
                    c_second++;
                end
                if ($urandom_range(0, 29) == 0) add_request(OP_UNUSED, t_value'($urandom));
            end
            add_request(OP_MERGE, t_value'($urandom), first_group || ($urandom_range(0, 9) == 0));
            first_group = 1'b0;
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_backlog.size() != 0 || i_start) @(posedge i_clk);
        while (merge_words_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (fail_count == 0 && merge_words_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
